[rtl/mpbm_pkg.sv]
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types and constants of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbm_pkg;

    // Automaton and table sizes
    localparam int NODE_W       = 10;
    localparam int ENTRY_W      = 10;
    localparam int BYTE_W       = 8;
    localparam int OFFSET_BITS  = 48;
    localparam int COUNT_W      = 5;
    localparam int NODE_COUNT   = 1 << NODE_W;
    localparam int MATCH_ENTRIES = 1 << ENTRY_W;
    localparam int TRANS_DEPTH  = NODE_COUNT * 256;
    localparam logic [COUNT_W-1:0] MAX_MATCHES_PER_NODE = 5'd16;

    // Stored record widths
    localparam int LIST_W  = COUNT_W + ENTRY_W;          // {count, start}
    localparam int MATCH_W = 8 + 16 + 2 + 8;             // {length, kind, id, format}
    localparam int RES_W   = OFFSET_BITS + MATCH_W;      // one result without last flag

    // Stream widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 88;
    localparam int OP_W        = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_TRANS  = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_LIST   = 3'd2;
    localparam logic [OP_W-1:0] OP_WR_ENTRY  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic scan_start;
        logic wr_trans;
        logic wr_list;
        logic wr_entry;
        logic restart;
        logic take_trans;
        logic take_list;
        logic entry_step;
        logic flush;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic list_empty;
        logic last_entry;
        logic hit;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/mpbm_ram.sv]
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/mpbm_ctrl.sv]
// ----------------------------------------------------------------------------
// mpbm_ctrl
// Sequencer: decodes input transactions and walks a node's match list.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [2:0]            in_op,
    output logic                       in_ready,
    input  wire mpbm_pkg::stat_t       stat,
    output mpbm_pkg::cmd_t             cmd
);

    import mpbm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_T,
        ST_WAIT_L,
        ST_ENTRY,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   stall;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // a found match must push the older pending one, which needs a free output slot
    assign stall    = stat.hit && stat.pend_valid && !stat.out_free;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_SCAN:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_WAIT_T;
                        end
                        OP_WR_TRANS: cmd.wr_trans = 1'b1;
                        OP_WR_LIST:  cmd.wr_list  = 1'b1;
                        OP_WR_ENTRY: cmd.wr_entry = 1'b1;
                        OP_RESTART:  cmd.restart  = 1'b1;
                        default:     ;
                    endcase
                end
            end
            ST_WAIT_T:
            begin
                cmd.take_trans = 1'b1;
                state_next     = ST_WAIT_L;
            end
            ST_WAIT_L:
            begin
                cmd.take_list = 1'b1;
                state_next    = stat.list_empty ? ST_IDLE : ST_ENTRY;
            end
            ST_ENTRY:
            begin
                if (!stall)
                begin
                    cmd.entry_step = 1'b1;
                    if (stat.last_entry)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mpbm_datapath.sv]
// ----------------------------------------------------------------------------
// mpbm_datapath
// Automaton tables, scan state, match-list walk and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [mpbm_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire mpbm_pkg::cmd_t                     cmd,
    output mpbm_pkg::stat_t                         stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mpbm_pkg::RES_W-1:0]              out_data,
    output logic                                    out_last
);

    import mpbm_pkg::*;

    // Input field unpacking
    logic [BYTE_W-1:0]      data_byte;
    logic [OFFSET_BITS-1:0] stream_offset;
    logic [NODE_W-1:0]      node;
    logic [NODE_W-1:0]      target_node;
    logic [ENTRY_W-1:0]     list_start;
    logic [COUNT_W-1:0]     list_count;
    logic [ENTRY_W-1:0]     entry;
    logic [MATCH_W-1:0]     entry_rec;

    assign data_byte     = in_data[7:0];
    assign stream_offset = in_data[55:8];
    assign node          = in_data[65:56];
    assign target_node   = in_data[75:66];
    assign list_start    = in_data[85:76];
    assign list_count    = in_data[90:86];
    assign entry         = in_data[100:91];
    assign entry_rec     = in_data[134:101];

    // Scan state
    logic [NODE_W-1:0]      cur_node_reg;
    logic [OFFSET_BITS-1:0] exp_off_reg;
    logic                   active_reg;
    logic [OFFSET_BITS-1:0] end_reg;
    logic [ENTRY_W-1:0]     start_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [COUNT_W-1:0]     k_reg;

    // Memory ports
    logic [NODE_W+BYTE_W-1:0] t_raddr;
    logic [NODE_W-1:0]        t_rdata;
    logic [LIST_W-1:0]        l_rdata;
    logic                     e_re;
    logic [ENTRY_W-1:0]       e_raddr;
    logic [MATCH_W-1:0]       e_rdata;

    // Derived values
    logic                     resync;
    logic [COUNT_W-1:0]       sat_cnt;
    logic [COUNT_W-1:0]       k_inc;
    logic [BYTE_W-1:0]        m_len;
    logic [RES_W-1:0]         new_res;

    // Pending and output registers
    logic                     pend_valid_reg;
    logic [RES_W-1:0]         pend_reg;
    logic                     out_valid_reg;
    logic [RES_W-1:0]         out_data_reg;
    logic                     out_last_reg;
    logic                     push_step;
    logic                     push_flush;

    assign resync  = !active_reg || (stream_offset != exp_off_reg);
    assign t_raddr = {resync ? {NODE_W{1'b0}} : cur_node_reg, data_byte};

    assign sat_cnt = (l_rdata[LIST_W-1:ENTRY_W] > MAX_MATCHES_PER_NODE) ?
                     MAX_MATCHES_PER_NODE : l_rdata[LIST_W-1:ENTRY_W];
    assign k_inc   = k_reg + 5'd1;

    // Entry read: first at list load, next on every step that is not the last
    assign e_re    = cmd.take_list || (cmd.entry_step && !stat.last_entry);
    assign e_raddr = cmd.take_list ? l_rdata[ENTRY_W-1:0]
                                   : start_reg + ENTRY_W'(k_inc);

    assign m_len   = e_rdata[MATCH_W-1:MATCH_W-8];
    assign new_res = {e_rdata, end_reg - OFFSET_BITS'(m_len)};

    assign push_step  = cmd.entry_step && stat.hit && pend_valid_reg;
    assign push_flush = cmd.flush && pend_valid_reg;

    assign stat.list_empty = (sat_cnt == '0);
    assign stat.last_entry = (k_inc == cnt_reg);
    assign stat.hit        = (end_reg >= OFFSET_BITS'(m_len));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // Tables
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(TRANS_DEPTH)) u_trans (
        .clk   (clk),
        .we    (cmd.wr_trans),
        .waddr ({node, data_byte}),
        .wdata (target_node),
        .re    (cmd.scan_start),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    mpbm_ram #(.WIDTH(LIST_W), .DEPTH(NODE_COUNT)) u_list (
        .clk   (clk),
        .we    (cmd.wr_list),
        .waddr (node),
        .wdata ({list_count, list_start}),
        .re    (cmd.take_trans),
        .raddr (t_rdata),
        .rdata (l_rdata)
    );

    mpbm_ram #(.WIDTH(MATCH_W), .DEPTH(MATCH_ENTRIES)) u_entry (
        .clk   (clk),
        .we    (cmd.wr_entry),
        .waddr (entry),
        .wdata (entry_rec),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // Scan state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_node_reg <= '0;
            exp_off_reg  <= '0;
            active_reg   <= 1'b0;
        end
        else if (cmd.restart)
        begin
            cur_node_reg <= '0;
            exp_off_reg  <= '0;
            active_reg   <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            exp_off_reg <= stream_offset + OFFSET_BITS'(1);
            active_reg  <= 1'b1;
        end
        else if (cmd.take_trans)
        begin
            cur_node_reg <= t_rdata;
        end
    end

    // List walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            end_reg <= stream_offset + OFFSET_BITS'(1);
        end
        if (cmd.take_list)
        begin
            start_reg <= l_rdata[ENTRY_W-1:0];
            cnt_reg   <= sat_cnt;
            k_reg     <= '0;
        end
        else if (cmd.entry_step)
        begin
            k_reg <= k_inc;
        end
    end

    // Pending result: held back until it is known whether it is the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.entry_step && stat.hit)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.entry_step && stat.hit)
        begin
            pend_reg <= new_res;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_step || push_flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_step || push_flush)
        begin
            out_data_reg <= pend_reg;
            out_last_reg <= push_flush;
        end
    end

endmodule

`default_nettype wire

[rtl/multi_pattern_byte_matcher.sv]
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Streaming Aho-Corasick scan engine with host-loaded automaton tables.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser opcode, tdata item fields
// m_axis    out  m_axis_tvalid/tready    tdata match, tlast last_of_run
//
// Table writes and restart complete without leaving the idle state.
// A scan byte reads the transition, list and entry RAMs in series, with one
// entry read per cycle over the list entries after saturation unless the
// output stalls, then a flush step; an empty list ends after the list read.
// Reset clears scan state and handshake control; tables hold no reset value.
// A full output register stalls the list walk when a result must be pushed, never the tables.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // data_byte, stream_offset, node, target_node, list_start, list_count,
    // entry, format_index, pattern_id, pattern_kind, pattern_length, pad
    input  wire logic [mpbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // opcode
    input  wire logic [mpbm_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // match_offset, match_format, match_pattern_id, match_kind, match_length, pad
    output logic [mpbm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tlast
);

    import mpbm_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [RES_W-1:0] res;

    mpbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpbm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

    // One command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan_start, cmd.wr_trans, cmd.wr_list, cmd.wr_entry, cmd.restart,
                  cmd.take_trans, cmd.take_list, cmd.entry_step, cmd.flush}))
        else $error("more than one datapath command");

    // A scan byte blocks the input until its list walk is over
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !s_axis_tready)
        else $error("input accepted during a scan");

    // A result is never pushed over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush && stat.pend_valid) |-> stat.out_free)
        else $error("flush into a full output register");

endmodule

`default_nettype wire
